>>> design/stec_pkg.sv
// Shared types and operation codes for the sorted table equal-count block.
package stec_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_COUNT  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // One transaction as it travels down the cell chain.
   typedef struct packed {
      logic                       valid;
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]         match_count;
      logic                       status;
   } item_type;

endpackage

>>> design/stec_cell.sv
// One table cell: holds a single entry and processes the transaction passing through it.
module stec_cell #(
   parameter int TABLE_DEPTH = 256,
   parameter int INDEX       = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  stec_pkg::item_type                    item_in,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]      fill_in,
   output stec_pkg::item_type                    item_out,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]      fill_out
);
   import stec_pkg::*;

   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [FILL_W-1:0] CELL_INDEX = FILL_W'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   item_type                  item_ff;
   item_type                  item_next_in;
   logic [FILL_W-1:0]         fill_ff;
   logic                      is_live;
   logic                      at_end;

   // The fill snapshot travels with the transaction, so this cell sees the
   // table size that was current when the transaction entered the chain.
   assign is_live = CELL_INDEX < fill_in;
   assign at_end  = CELL_INDEX == fill_in;

   always_comb begin
      item_next_in = item_in;
      entry_in     = entry_ff;
      if (item_in.valid) begin
         case (item_in.op)
            OP_INSERT: begin
               // A larger live entry is displaced and carried on to the next cell.
               if (is_live && (entry_ff > item_in.value)) begin
                  entry_in           = item_in.value;
                  item_next_in.value = entry_ff;
               end else if (at_end) begin
                  entry_in = item_in.value;
               end
            end
            OP_COUNT: begin
               if (is_live && (entry_ff == item_in.value)) begin
                  item_next_in.match_count = item_in.match_count + COUNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
         fill_ff  <= fill_in;
      end
      if (reset) begin
         item_ff <= '0;
      end else if (advance) begin
         item_ff <= item_next_in;
      end
   end

   assign item_out = item_ff;
   assign fill_out = fill_ff;

endmodule

>>> design/sorted_table_equal_count.sv
// Top level of the sorted table equal-count block: admission, fill counter and cell chain.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_operation, req_value
//   rsp      out        rsp_valid / rsp_ready  rsp_match_count, rsp_status
//
// Each transaction walks the chain of TABLE_DEPTH cells, one cell per cycle while the
// chain advances, passing through every cell register in order; one transaction enters
// per cycle unless the chain is held.
// The last cell's register is the output register; while a result waits on rsp_ready
// the whole chain holds and req_ready is low.
// Reset empties the chain and clears the fill counter; table entries are not cleared.
module sorted_table_equal_count #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic signed [stec_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [stec_pkg::COUNT_W-1:0]         rsp_match_count,
   output logic                                 rsp_status
);
   import stec_pkg::*;

   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(TABLE_DEPTH);

   item_type          chain_item [TABLE_DEPTH+1];
   logic [FILL_W-1:0] chain_fill [TABLE_DEPTH+1];
   item_type          head_item;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              advance;
   logic              is_full;
   op_type            req_op;

   assign req_op    = op_type'(req_operation);
   assign is_full   = fill_ff == FULL_FILL;
   assign advance   = !chain_item[TABLE_DEPTH].valid || rsp_ready;
   assign req_ready = advance;

   // Build the transaction entering the chain; a dropped insert travels as a no-op.
   always_comb begin
      head_item.valid       = req_valid;
      head_item.op          = req_op;
      head_item.value       = req_value;
      head_item.match_count = '0;
      head_item.status      = 1'b0;
      if ((req_op == OP_INSERT) && is_full) begin
         head_item.op     = OP_NONE;
         head_item.status = 1'b1;
      end
   end

   assign chain_item[0] = head_item;
   assign chain_fill[0] = fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (req_valid && advance) begin
         case (req_op)
            OP_CLEAR: begin
               fill_in = '0;
            end
            OP_INSERT: begin
               if (!is_full) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      stec_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX       (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .item_in  (chain_item[k]),
         .fill_in  (chain_fill[k]),
         .item_out (chain_item[k+1]),
         .fill_out (chain_fill[k+1])
      );
   end

   assign rsp_valid       = chain_item[TABLE_DEPTH].valid;
   assign rsp_match_count = chain_item[TABLE_DEPTH].match_count;
   assign rsp_status      = chain_item[TABLE_DEPTH].status;

   chk_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("fill counter exceeds table depth");

   chk_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == OP_CLEAR)) |=> (fill_ff == '0))
      else $error("accepted clear did not empty the table");

   chk_drop_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_match_count == '0))
      else $error("dropped insert carries a nonzero count");

   chk_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while the result is stalled");

endmodule
